### sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, held off while reset is low.
`define TOD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, limited to cycles in which a result is on offer.
`define TOD_ASSERT_OUT(name, prop, msg) \
    `TOD_ASSERT(name, out_valid |-> (prop), msg)

`endif

### sv/tod_pkg.sv
// Package with the types, opcodes and constants of the time-of-day clock.
package tod_pkg;

    // Digit entry positions.
    typedef logic [2:0] pos_t;
    localparam pos_t ENTRY_IDLE = 3'd6;
    localparam pos_t POS_TENS_HOUR = 3'd0;
    localparam pos_t POS_ONES_HOUR = 3'd1;
    localparam pos_t POS_TENS_MIN = 3'd2;
    localparam pos_t POS_ONES_MIN = 3'd3;
    localparam pos_t POS_TENS_SEC = 3'd4;
    localparam pos_t POS_ONES_SEC = 3'd5;

    // Item opcodes; codes 5 to 7 do nothing.
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_BEGIN   = 3'd1,
        OP_DIGIT   = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_SILENCE = 3'd4
    } op_t;

    // Target codes.
    localparam logic TARGET_CLOCK = 1'b0;
    localparam logic TARGET_ALARM = 1'b1;

    // Time and digit limits.
    localparam logic [5:0] TPS_RESET      = 6'd20;
    localparam logic [6:0] SEC_PER_MIN    = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR   = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY  = 6'd24;
    localparam logic [7:0] PAIR_HOUR_LIM  = 8'd24;
    localparam logic [7:0] PAIR_MS_LIM    = 8'd60;
    localparam logic [3:0] DIGIT_MAX      = 4'd9;
    localparam logic [3:0] TENS_HOUR_MAX  = 4'd2;
    localparam logic [3:0] TENS_MS_MAX    = 4'd5;
    localparam logic [7:0] DECIMAL_BASE   = 8'd10;

    // Time value that digit entry hands to the timekeeping side.
    typedef struct packed {
        logic       load;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } time_load_t;

    // Timekeeping state after an item, plus the chime pulse.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       alarm;
        logic       chime;
    } time_status_t;

    // Two decimal digits combined into one value.
    function automatic logic [7:0] pair_value(input logic [3:0] tens,
                                              input logic [3:0] ones);
        return {4'b0000, tens} * DECIMAL_BASE + {4'b0000, ones};
    endfunction

endpackage

### sv/tod_entry.sv
// Digit entry: position tracking, digit checks and the time value to load.
module tod_entry import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [2:0] opcode,
    input  logic [3:0] digit,
    output pos_t       entry_position,
    output logic       digit_accepted,
    output time_load_t load
);

    pos_t       pos_reg;
    pos_t       pos_next;
    logic [3:0] digit_reg [6];
    logic [3:0] tens_digit;
    logic [7:0] pair;
    logic       digit_ok;
    logic       accepted;
    logic [7:0] load_hours;
    logic [7:0] load_minutes;
    logic [7:0] load_seconds;

    // Pick the stored tens digit that pairs with the current position.
    always_comb
    begin
        case (pos_reg)
            POS_ONES_HOUR: tens_digit = digit_reg[0];
            POS_ONES_MIN:  tens_digit = digit_reg[2];
            default:       tens_digit = digit_reg[4];
        endcase
    end

    assign pair = pair_value(tens_digit, digit);

    // Check the digit against the rules of its position.
    always_comb
    begin
        case (pos_reg)
            POS_TENS_HOUR: digit_ok = (digit <= TENS_HOUR_MAX);
            POS_ONES_HOUR: digit_ok = (digit <= DIGIT_MAX) && (pair < PAIR_HOUR_LIM);
            POS_TENS_MIN:  digit_ok = (digit <= TENS_MS_MAX);
            POS_ONES_MIN:  digit_ok = (digit <= DIGIT_MAX) && (pair < PAIR_MS_LIM);
            POS_TENS_SEC:  digit_ok = (digit <= TENS_MS_MAX);
            POS_ONES_SEC:  digit_ok = (digit <= DIGIT_MAX) && (pair < PAIR_MS_LIM);
            default:       digit_ok = 1'b0;
        endcase
    end

    assign accepted = (opcode == OP_DIGIT) && digit_ok;

    // Next position: begin restarts, an accepted digit moves on.
    always_comb
    begin
        if (opcode == OP_BEGIN)
        begin
            pos_next = POS_TENS_HOUR;
        end
        else if (accepted)
        begin
            pos_next = pos_reg + 3'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // The sixth digit completes the time; it comes straight from the input.
    assign load_hours   = pair_value(digit_reg[0], digit_reg[1]);
    assign load_minutes = pair_value(digit_reg[2], digit_reg[3]);
    assign load_seconds = pair_value(digit_reg[4], digit);

    always_comb
    begin
        load.load    = accepted && (pos_reg == POS_ONES_SEC);
        load.hours   = load_hours[4:0];
        load.minutes = load_minutes[5:0];
        load.seconds = load_seconds[5:0];
    end

    assign entry_position = pos_next;
    assign digit_accepted = accepted;

    // Position register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= ENTRY_IDLE;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
        end
    end

    // Stored digits, one written per accepted digit item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
        end
        else if (fire && accepted)
        begin
            digit_reg[pos_reg] <= digit;
        end
    end

endmodule

### sv/tod_time.sv
// Timekeeping: prescaler, clock time, alarm time and alarm flag.
module tod_time import tod_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [2:0]   opcode,
    input  logic         target,
    input  logic [5:0]   ticks_per_second,
    input  time_load_t   load,
    output time_status_t status
);

    logic [5:0] tick_reg,   tick_next;
    logic [4:0] hours_reg,  hours_next;
    logic [5:0] min_reg,    min_next;
    logic [5:0] sec_reg,    sec_next;
    logic [4:0] a_hours_reg, a_hours_next;
    logic [5:0] a_min_reg,   a_min_next;
    logic [5:0] a_sec_reg,   a_sec_next;
    logic       alarm_reg,   alarm_next;
    logic       chime;

    logic [5:0] limit;
    logic [6:0] tick_inc;
    logic       sec_done;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [4:0] adv_hours;
    logic [5:0] adv_min;
    logic [5:0] adv_sec;
    logic       adv_chime;
    logic       adv_match;

    // Prescaler: a setting of zero counts as one.
    assign limit    = (ticks_per_second == 6'd0) ? 6'd1 : ticks_per_second;
    assign tick_inc = {1'b0, tick_reg} + 7'd1;
    assign sec_done = (tick_inc >= {1'b0, limit});

    // Time one second later, with carries.
    assign sec_inc  = {1'b0, sec_reg} + 7'd1;
    assign min_inc  = {1'b0, min_reg} + 7'd1;
    assign hour_inc = {1'b0, hours_reg} + 6'd1;

    always_comb
    begin
        adv_hours = hours_reg;
        adv_min   = min_reg;
        adv_sec   = sec_inc[5:0];
        adv_chime = 1'b0;
        if (sec_inc >= SEC_PER_MIN)
        begin
            adv_sec = 6'd0;
            adv_min = min_inc[5:0];
            if (min_inc >= MIN_PER_HOUR)
            begin
                adv_min   = 6'd0;
                adv_chime = 1'b1;
                adv_hours = (hour_inc >= HOURS_PER_DAY) ? 5'd0 : hour_inc[4:0];
            end
        end
    end

    assign adv_match = (adv_hours == a_hours_reg) && (adv_min == a_min_reg) &&
                       (adv_sec == a_sec_reg);

    // Next state for each kind of item.
    always_comb
    begin
        tick_next    = tick_reg;
        hours_next   = hours_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        a_hours_next = a_hours_reg;
        a_min_next   = a_min_reg;
        a_sec_next   = a_sec_reg;
        alarm_next   = alarm_reg;
        chime        = 1'b0;
        case (opcode)
            OP_TICK:
            begin
                if (sec_done)
                begin
                    tick_next  = 6'd0;
                    hours_next = adv_hours;
                    min_next   = adv_min;
                    sec_next   = adv_sec;
                    chime      = adv_chime;
                    alarm_next = alarm_reg | adv_match;
                end
                else
                begin
                    tick_next = tick_inc[5:0];
                end
            end
            OP_DIGIT:
            begin
                if (load.load && (target == TARGET_CLOCK))
                begin
                    hours_next = load.hours;
                    min_next   = load.minutes;
                    sec_next   = load.seconds;
                end
                else if (load.load)
                begin
                    a_hours_next = load.hours;
                    a_min_next   = load.minutes;
                    a_sec_next   = load.seconds;
                end
            end
            OP_CLEAR:
            begin
                if (target == TARGET_CLOCK)
                begin
                    tick_next  = 6'd0;
                    hours_next = 5'd0;
                    min_next   = 6'd0;
                    sec_next   = 6'd0;
                end
                else
                begin
                    a_hours_next = 5'd0;
                    a_min_next   = 6'd0;
                    a_sec_next   = 6'd0;
                end
            end
            OP_SILENCE:
            begin
                alarm_next = 1'b0;
            end
            default:
            begin
                alarm_next = alarm_reg;
            end
        endcase
    end

    always_comb
    begin
        status.hours   = hours_next;
        status.minutes = min_next;
        status.seconds = sec_next;
        status.alarm   = alarm_next;
        status.chime   = chime;
    end

    // State registers, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= 6'd0;
            hours_reg   <= 5'd0;
            min_reg     <= 6'd0;
            sec_reg     <= 6'd0;
            a_hours_reg <= 5'd0;
            a_min_reg   <= 6'd0;
            a_sec_reg   <= 6'd0;
            alarm_reg   <= 1'b0;
        end
        else if (fire)
        begin
            tick_reg    <= tick_next;
            hours_reg   <= hours_next;
            min_reg     <= min_next;
            sec_reg     <= sec_next;
            a_hours_reg <= a_hours_next;
            a_min_reg   <= a_min_next;
            a_sec_reg   <= a_sec_next;
            alarm_reg   <= alarm_next;
        end
    end

endmodule

### sv/time_of_day_clock_with_alarm.sv
// Top level of the 24-hour clock with alarm and digit-entry setter.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    opcode, digit, target
//   out      output     out_valid / out_ready  hours, minutes, seconds, alarm_ringing,
//                                              hour_chime, entry_position, digit_accepted
//   cfg      input      cfg_valid / cfg_ready  cfg_data (ticks_per_second)
//
// Each item is worked out from the state registers in the cycle it is accepted, and its
// result sits in the output register from the next cycle on.
// One item per cycle is sustained while out_ready stays high; the single-pass update of
// the state registers sets that rate.
// in_ready drops only while a result is held and out_ready is low.
// Reset puts the clock and alarm at 00:00:00, silences the alarm, idles digit entry
// and sets ticks_per_second to 20. cfg_ready is always high.
module time_of_day_clock_with_alarm import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [3:0] digit,
    input  logic       target,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] hours,
    output logic [5:0] minutes,
    output logic [5:0] seconds,
    output logic       alarm_ringing,
    output logic       hour_chime,
    output logic [2:0] entry_position,
    output logic       digit_accepted,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

    logic         fire;
    logic [5:0]   tps_reg;
    time_load_t   load;
    time_status_t status;
    pos_t         pos_now;
    logic         accepted_now;

    logic         out_valid_reg;
    time_status_t status_reg;
    pos_t         pos_reg;
    logic         accepted_reg;

    // Input handshake: take an item whenever the result register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_valid)
        begin
            tps_reg <= cfg_data;
        end
    end

    // Digit entry.
    tod_entry u_entry
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .opcode         (opcode),
        .digit          (digit),
        .entry_position (pos_now),
        .digit_accepted (accepted_now),
        .load           (load)
    );

    // Timekeeping.
    tod_time u_time
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .opcode           (opcode),
        .target           (target),
        .ticks_per_second (tps_reg),
        .load             (load),
        .status           (status)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status;
            pos_reg      <= pos_now;
            accepted_reg <= accepted_now;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hours          = status_reg.hours;
    assign minutes        = status_reg.minutes;
    assign seconds        = status_reg.seconds;
    assign alarm_ringing  = status_reg.alarm;
    assign hour_chime     = status_reg.chime;
    assign entry_position = pos_reg;
    assign digit_accepted = accepted_reg;

endmodule

### sv/tod_checker.sv
// Port-level checker for the time-of-day clock, bound to the top level.
`include "assert_macros.svh"

module tod_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] hours,
    input logic [5:0] minutes,
    input logic [5:0] seconds,
    input logic       alarm_ringing,
    input logic       hour_chime,
    input logic [2:0] entry_position,
    input logic       digit_accepted
);

    // A held result keeps its time and alarm flag until it is taken.
    `TOD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hours) && $stable(minutes) && $stable(seconds) && $stable(alarm_ringing), "result changed while stalled")

    // The clock never shows an impossible time.
    `TOD_ASSERT_OUT(a_time_range, hours <= 5'd23 && minutes <= 6'd59 && seconds <= 6'd59, "time out of range")

    // A chime comes only with the top of the hour.
    `TOD_ASSERT_OUT(a_chime_top, !hour_chime || (minutes == 6'd0 && seconds == 6'd0), "chime off the hour")

    // A tick and a digit cannot both happen in one item.
    `TOD_ASSERT_OUT(a_chime_digit, !(hour_chime && digit_accepted), "chime with accepted digit")

    // An accepted digit always moves entry to a position from one to six.
    `TOD_ASSERT_OUT(a_digit_pos, !digit_accepted || (entry_position != 3'd0 && entry_position <= 3'd6), "bad position after digit")

endmodule

bind time_of_day_clock_with_alarm tod_checker u_tod_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hours          (hours),
    .minutes        (minutes),
    .seconds        (seconds),
    .alarm_ringing  (alarm_ringing),
    .hour_chime     (hour_chime),
    .entry_position (entry_position),
    .digit_accepted (digit_accepted)
);

### dv/time_of_day_clock_with_alarm_test.sv
// Self-checking testbench for the 24-hour clock with alarm and digit-entry setter.
`timescale 1ns / 1ps

module time_of_day_clock_with_alarm_test;
    import tod_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 4;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_WAIT = 12;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int RUN_LIMIT_NS = 3_000_000;
    localparam int SECONDS_PER_HOUR = 3600;
    localparam int SECONDS_PER_DAY = 86400;
    localparam int DIGIT_TOP = 15;
    localparam int HIGH_PRESCALE = 40;
    localparam logic [5:0] RATE_MAX = 6'd63;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;

    // One readout of the block after an item.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       ringing;
        logic       chime;
        logic [2:0] position;
        logic       accepted;
    } tod_readout_t;

    // Predicts the clock readout for every accepted item and checks the block against it.
    class clock_readout_board;
        int rate;
        int prescale;
        int clk_h, clk_m, clk_s;
        int alm_h, alm_m, alm_s;
        bit ringing;
        int position;
        int stored[6];
        int errors;
        int results_seen;
        tod_readout_t readouts_due[$];

        function new();
            rate = TPS_RESET;
            prescale = 0;
            clk_h = 0;
            clk_m = 0;
            clk_s = 0;
            alm_h = 0;
            alm_m = 0;
            alm_s = 0;
            ringing = 1'b0;
            position = ENTRY_IDLE;
            foreach (stored[k])
                stored[k] = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t: readout %0d: %s", $time, results_seen, msg);
        endtask

        // Works out the readout that an accepted item leads to.
        function void take_item(logic [2:0] op, logic [3:0] d, logic tgt);
            int limit;
            bit chime;
            bit ok;
            tod_readout_t r;
            chime = 1'b0;
            ok = 1'b0;
            case (op)
                OP_TICK:
                begin
                    limit = (rate == 0) ? 1 : rate;
                    if (prescale + 1 >= limit)
                    begin
                        prescale = 0;
                        clk_s++;
                        if (clk_s >= SEC_PER_MIN)
                        begin
                            clk_s = 0;
                            clk_m++;
                            if (clk_m >= MIN_PER_HOUR)
                            begin
                                clk_m = 0;
                                chime = 1'b1;
                                clk_h++;
                                if (clk_h >= HOURS_PER_DAY)
                                    clk_h = 0;
                            end
                        end
                        // The alarm is compared only after a second has passed.
                        if (clk_h == alm_h && clk_m == alm_m && clk_s == alm_s)
                            ringing = 1'b1;
                    end
                    else
                        prescale = prescale + 1;
                end
                OP_BEGIN:
                    position = POS_TENS_HOUR;
                OP_DIGIT:
                begin
                    case (position)
                        POS_TENS_HOUR:
                            ok = d <= TENS_HOUR_MAX;
                        POS_ONES_HOUR:
                            ok = d <= DIGIT_MAX && stored[0] * DECIMAL_BASE + d < PAIR_HOUR_LIM;
                        POS_TENS_MIN, POS_TENS_SEC:
                            ok = d <= TENS_MS_MAX;
                        POS_ONES_MIN, POS_ONES_SEC:
                            ok = d <= DIGIT_MAX
                                 && stored[position - 1] * DECIMAL_BASE + d < PAIR_MS_LIM;
                        default:
                            ok = 1'b0;
                    endcase
                    if (ok)
                    begin
                        stored[position] = d;
                        position++;
                        // The sixth digit loads whichever time the item targets.
                        if (position == ENTRY_IDLE)
                        begin
                            if (tgt == TARGET_CLOCK)
                            begin
                                clk_h = stored[0] * DECIMAL_BASE + stored[1];
                                clk_m = stored[2] * DECIMAL_BASE + stored[3];
                                clk_s = stored[4] * DECIMAL_BASE + stored[5];
                            end
                            else
                            begin
                                alm_h = stored[0] * DECIMAL_BASE + stored[1];
                                alm_m = stored[2] * DECIMAL_BASE + stored[3];
                                alm_s = stored[4] * DECIMAL_BASE + stored[5];
                            end
                        end
                    end
                end
                OP_CLEAR:
                begin
                    if (tgt == TARGET_CLOCK)
                    begin
                        clk_h = 0;
                        clk_m = 0;
                        clk_s = 0;
                        prescale = 0;
                    end
                    else
                    begin
                        alm_h = 0;
                        alm_m = 0;
                        alm_s = 0;
                    end
                end
                OP_SILENCE:
                    ringing = 1'b0;
                default:
                    ;
            endcase
            r.hours = 5'(clk_h);
            r.minutes = 6'(clk_m);
            r.seconds = 6'(clk_s);
            r.ringing = ringing;
            r.chime = chime;
            r.position = 3'(position);
            r.accepted = ok;
            readouts_due.push_back(r);
        endfunction

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        // Compares one readout from the block with the oldest prediction.
        task check_readout(tod_readout_t got);
            tod_readout_t want;
            results_seen++;
            if (readouts_due.size() == 0)
            begin
                report_mismatch("arrived with no item outstanding");
                return;
            end
            want = readouts_due.pop_front();
            compare_field("hours", got.hours, want.hours);
            compare_field("minutes", got.minutes, want.minutes);
            compare_field("seconds", got.seconds, want.seconds);
            compare_field("alarm_ringing", got.ringing, want.ringing);
            compare_field("hour_chime", got.chime, want.chime);
            compare_field("entry_position", got.position, want.position);
            compare_field("digit_accepted", got.accepted, want.accepted);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] opcode;
    logic [3:0] digit;
    logic       target;
    logic       out_valid;
    logic       out_ready;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       alarm_ringing;
    logic       hour_chime;
    logic [2:0] entry_position;
    logic       digit_accepted;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;

    clock_readout_board readout;
    int items_sent = 0;
    bit steady_flow = 1'b0;
    bit hold_output = 1'b0;

    time_of_day_clock_with_alarm u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .digit          (digit),
        .target         (target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hours          (hours),
        .minutes        (minutes),
        .seconds        (seconds),
        .alarm_ringing  (alarm_ringing),
        .hour_chime     (hour_chime),
        .entry_position (entry_position),
        .digit_accepted (digit_accepted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    // Watches both channels and feeds the readout board.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                readout.take_item(opcode, digit, target);
            if (out_valid && out_ready)
                readout.check_readout(tod_readout_t'({hours, minutes, seconds, alarm_ringing,
                                                      hour_chime, entry_position,
                                                      digit_accepted}));
        end
    end

    function automatic int draw_wait();
        if (steady_flow)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int ticks_in_second();
        return (readout.rate == 0) ? 1 : readout.rate;
    endfunction

    // Either end of the range, or anything in between.
    function automatic int pick_field(int top);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // Receiver: random stalls per readout, plus one long hold on request.
    initial
    begin
        int pause;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else
            begin
                pause = draw_wait();
                if (pause > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (pause) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offers one item after a random gap and waits until it is taken.
    task automatic send_item(input logic [2:0] op, input logic [3:0] d, input logic tgt);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        digit <= d;
        target <= tgt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op <= OP_SILENCE)
            items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(OP_TICK, 4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
    endtask

    // Stops offering and waits until every predicted readout has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readout.readouts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [5:0] rate_value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= rate_value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        readout.rate = rate_value;
    endtask

    // Keys in a time as six digits, with the odd rejected digit or abandoned entry.
    task automatic enter_time(input int h, input int m, input int s, input logic tgt);
        int value[6];
        int lowest_bad;
        value[0] = h / DECIMAL_BASE;
        value[1] = h % DECIMAL_BASE;
        value[2] = m / DECIMAL_BASE;
        value[3] = m % DECIMAL_BASE;
        value[4] = s / DECIMAL_BASE;
        value[5] = s % DECIMAL_BASE;
        send_item(OP_BEGIN, 4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
        for (int p = 0; p < ENTRY_IDLE; p++)
        begin
            if ($urandom_range(0, 24) == 0)
                return;
            if ($urandom_range(0, 4) == 0)
            begin
                case (p)
                    POS_TENS_HOUR:
                        lowest_bad = TENS_HOUR_MAX + 1;
                    POS_TENS_MIN, POS_TENS_SEC:
                        lowest_bad = TENS_MS_MAX + 1;
                    POS_ONES_HOUR:
                        lowest_bad = (value[0] == TENS_HOUR_MAX)
                                     ? PAIR_HOUR_LIM - value[0] * DECIMAL_BASE
                                     : DIGIT_MAX + 1;
                    default:
                        lowest_bad = DIGIT_MAX + 1;
                endcase
                send_item(OP_DIGIT, 4'($urandom_range(lowest_bad, DIGIT_TOP)),
                          1'($urandom_range(0, 1)));
            end
            send_item(OP_DIGIT, 4'(value[p]),
                      (p == POS_ONES_SEC) ? tgt : 1'($urandom_range(0, 1)));
        end
    endtask

    // Sets the alarm a few seconds ahead of the clock and ticks past it.
    task automatic alarm_soon();
        int ahead;
        int total;
        ahead = $urandom_range(1, 3);
        total = (readout.clk_h * SECONDS_PER_HOUR + readout.clk_m * SEC_PER_MIN
                 + readout.clk_s + ahead) % SECONDS_PER_DAY;
        enter_time(total / SECONDS_PER_HOUR, (total / SEC_PER_MIN) % MIN_PER_HOUR,
                   total % SEC_PER_MIN, TARGET_ALARM);
        send_ticks((ahead + 1) * ticks_in_second());
    endtask

    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            enter_time(pick_field(HOURS_PER_DAY - 1), pick_field(MIN_PER_HOUR - 1),
                       pick_field(SEC_PER_MIN - 1), 1'($urandom_range(0, 1)));
        else if (pick < 36)
            alarm_soon();
        else if (pick < 42)
        begin
            // Park the clock just short of an hour rollover.
            enter_time(($urandom_range(0, 1) == 0) ? HOURS_PER_DAY - 1
                                                   : $urandom_range(0, HOURS_PER_DAY - 1),
                       MIN_PER_HOUR - 1, $urandom_range(SEC_PER_MIN - 2, SEC_PER_MIN - 1),
                       TARGET_CLOCK);
            send_ticks(2 * ticks_in_second());
        end
        else if (pick < 44)
            wait_drained();
        else if (pick < 46)
            steady_flow = !steady_flow;
        else if (pick < 68)
            send_ticks(1);
        else if (pick < 74)
            send_ticks(ticks_in_second());
        else if (pick < 80)
            send_item(OP_SILENCE, 4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
        else if (pick < 86)
            send_item(OP_CLEAR, 4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
        else if (pick < 90)
            send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                      4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
        else if (pick < 96)
            send_item(OP_DIGIT, 4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
        else
            send_item(OP_BEGIN, 4'($urandom_range(0, DIGIT_TOP)), 1'($urandom_range(0, 1)));
    endtask

    // Main sequence: reset, directed items at the reset rate, then random phases.
    initial
    begin
        logic [5:0] rates[6];
        int phase_goal;
        readout = new();
        in_valid <= 1'b0;
        opcode <= OP_TICK;
        digit <= 4'd0;
        target <= TARGET_CLOCK;
        cfg_valid <= 1'b0;
        cfg_data <= TPS_RESET;
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Digit while idle, then an entry of 23:59:59 with rejects along the way.
        send_item(OP_DIGIT, 4'd5, TARGET_CLOCK);
        send_item(OP_BEGIN, 4'd0, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd3, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd15, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd2, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd4, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd3, TARGET_CLOCK);
        send_item(OP_DIGIT, 4'd6, TARGET_CLOCK);
        send_item(OP_DIGIT, 4'd5, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd9, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd5, TARGET_ALARM);
        send_item(OP_DIGIT, 4'd9, TARGET_CLOCK);
        // One second at the reset rate: day wrap, chime and the alarm at midnight.
        send_ticks(TPS_RESET + 1);
        send_item(OP_SPARE_FIRST, 4'd0, TARGET_CLOCK);
        send_item(OP_SPARE_LAST, 4'd15, TARGET_ALARM);
        send_item(OP_SILENCE, 4'd0, TARGET_CLOCK);
        // Restarting an entry keeps the stored tens of hours until overwritten.
        send_item(OP_BEGIN, 4'd0, TARGET_CLOCK);
        send_item(OP_DIGIT, 4'd1, TARGET_CLOCK);
        send_item(OP_BEGIN, 4'd0, TARGET_CLOCK);
        send_item(OP_DIGIT, 4'd9, TARGET_CLOCK);
        send_ticks(3);
        send_item(OP_CLEAR, 4'd0, TARGET_ALARM);
        send_item(OP_CLEAR, 4'd0, TARGET_CLOCK);

        rates = '{6'd1, RATE_MAX, 6'd3, 6'd0, 6'd2, 6'd0};
        rates[5] = 6'($urandom_range(1, RATE_MAX));
        foreach (rates[ph])
        begin
            // Leave the prescaler high so the lower rate ends a second on the next tick.
            if (readout.rate == RATE_MAX)
                while (readout.prescale < HIGH_PRESCALE)
                    send_ticks(1);
            write_rate(rates[ph]);
            steady_flow = ($urandom_range(0, 2) == 0);
            if (ph == 0)
                hold_output = 1'b1;
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal)
                random_step();
        end

        wait_drained();
        if (readout.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/tod_pkg.sv
sv/tod_entry.sv
sv/tod_time.sv
sv/time_of_day_clock_with_alarm.sv
sv/tod_checker.sv
dv/time_of_day_clock_with_alarm_test.sv
